@@ design/framebuffer_dirty_rect_tracker_assert.svh @@
// Assertion shorthands for the dirty rectangle tracker.
// Sampled on clk, disabled while rst is high.
`ifndef FRAMEBUFFER_DIRTY_RECT_TRACKER_ASSERT_SVH
`define FRAMEBUFFER_DIRTY_RECT_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define FBDRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBDRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fbdrt_pkg.sv @@
package fbdrt_pkg;

  localparam int NATIVE_WIDTH_DEF  = 160;
  localparam int NATIVE_HEIGHT_DEF = 128;
  localparam int SOURCE_WIDTH_DEF  = 256;

  localparam logic [15:0] COLOR_WHITE = 16'hFFFF;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [2:0] REG_ROTATION = 3'd0;
  localparam logic [2:0] REG_X_OFFSET = 3'd1;
  localparam logic [2:0] REG_Y_OFFSET = 3'd2;
  localparam logic [2:0] REG_DRAW_EN  = 3'd3;
  localparam logic [2:0] REG_UPD_EN   = 3'd4;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_SCALED = 2'd2,
    ACT_FLUSH  = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic signed [11:0] coord_x;
    logic signed [11:0] coord_y;
    logic [15:0]        pixel_color;
    logic               full_width_req;
    logic               full_height_req;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_color;
    logic        pixel_changed;
    logic        window_valid;
    logic [7:0]  window_left;
    logic [7:0]  window_top;
    logic [7:0]  window_right;
    logic [7:0]  window_bottom;
    logic        full_width_window;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         rotation;
    logic signed [11:0] x_offset;
    logic signed [11:0] y_offset;
    logic               drawing_enabled;
    logic               updates_accepted;
  } cfg_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic stage_pre;
    logic stage_clip;
    logic stage_read;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/fbdrt_cfg.sv @@
module fbdrt_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbdrt_pkg::APB_AW-1:0]  paddr,
  input  logic [fbdrt_pkg::APB_DW-1:0]  pwdata,
  output logic [fbdrt_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output fbdrt_pkg::cfg_t               cfg
);
  import fbdrt_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation         <= 2'd0;
      cfg.x_offset         <= 12'sd0;
      cfg.y_offset         <= 12'sd0;
      cfg.drawing_enabled  <= 1'b1;
      cfg.updates_accepted <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROTATION: cfg.rotation         <= pwdata[1:0];
        REG_X_OFFSET: cfg.x_offset         <= pwdata[11:0];
        REG_Y_OFFSET: cfg.y_offset         <= pwdata[11:0];
        REG_DRAW_EN:  cfg.drawing_enabled  <= pwdata[0];
        REG_UPD_EN:   cfg.updates_accepted <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROTATION: prdata = {30'd0, cfg.rotation};
      REG_X_OFFSET: prdata = {{20{cfg.x_offset[11]}}, cfg.x_offset};
      REG_Y_OFFSET: prdata = {{20{cfg.y_offset[11]}}, cfg.y_offset};
      REG_DRAW_EN:  prdata = {31'd0, cfg.drawing_enabled};
      REG_UPD_EN:   prdata = {31'd0, cfg.updates_accepted};
      default:      prdata = '0;
    endcase
  end

endmodule

@@ design/fbdrt_ctrl.sv @@
module fbdrt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  fbdrt_pkg::dp_status_t status,
  output fbdrt_pkg::ctrl_cmd_t  cmd
);
  import fbdrt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PRE,
    S_CLIP,
    S_READ,
    S_COMMIT
  } state_t;

  state_t state;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == S_CLEAR);
    cmd.load       = (state == S_IDLE) && item_valid;
    cmd.stage_pre  = (state == S_PRE);
    cmd.stage_clip = (state == S_CLIP);
    cmd.stage_read = (state == S_READ);
    cmd.commit     = (state == S_COMMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR:  if (status.clear_last) state <= S_IDLE;
        S_IDLE:   if (item_valid) state <= S_PRE;
        S_PRE:    state <= S_CLIP;
        S_CLIP:   state <= S_READ;
        S_READ:   state <= S_COMMIT;
        // hold until the output register can take the beat
        S_COMMIT: if (status.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/fbdrt_datapath.sv @@
module fbdrt_datapath #(
  parameter int NATIVE_WIDTH  = fbdrt_pkg::NATIVE_WIDTH_DEF,
  parameter int NATIVE_HEIGHT = fbdrt_pkg::NATIVE_HEIGHT_DEF,
  parameter int SOURCE_WIDTH  = fbdrt_pkg::SOURCE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fbdrt_pkg::cfg_t       cfg,
  input  fbdrt_pkg::ctrl_cmd_t  cmd,
  output fbdrt_pkg::dp_status_t status,
  input  fbdrt_pkg::in_item_t   item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output fbdrt_pkg::out_item_t  result
);
  import fbdrt_pkg::*;

  localparam int DEPTH = NATIVE_WIDTH * NATIVE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0]      ADDR_ONE  = AW'(1);
  localparam logic [AW-1:0]      W_AW      = AW'(NATIVE_WIDTH);
  localparam logic [7:0]         W_M1      = 8'(NATIVE_WIDTH - 1);
  localparam logic [7:0]         H_M1      = 8'(NATIVE_HEIGHT - 1);
  localparam logic [7:0]         W_8       = 8'(NATIVE_WIDTH);
  localparam logic [7:0]         H_8       = 8'(NATIVE_HEIGHT);
  localparam logic [8:0]         W_9       = 9'(NATIVE_WIDTH);
  localparam logic [8:0]         H_9       = 9'(NATIVE_HEIGHT);
  localparam logic signed [12:0] SW_13     = 13'(SOURCE_WIDTH);
  localparam logic signed [8:0]  EMPTY_HI  = -9'sd1;

  logic [15:0] mem [DEPTH];

  logic [AW-1:0] clr_addr;

  // captured item
  action_t            act;
  logic signed [11:0] cx, cy;
  logic [15:0]        color;
  logic               fw, fh;

  // after offset
  logic signed [12:0] ox, oy;
  logic               pre_ok;

  // after clip and rotation
  logic [7:0] nx, ny;
  logic       hit;

  logic [AW-1:0] addr;
  logic [15:0]   rd_data;

  // dirty bounds
  logic [7:0]        dl, dt;
  logic signed [8:0] dr, db;

  logic [8:0]         lw, lh;
  logic signed [11:0] lx, ly;
  logic               src_ok, fits;
  logic               pre_ok_next;
  logic signed [12:0] ox_next, oy_next;
  logic               in_bounds;
  logic [7:0]         ux, uy;
  logic [7:0]         nx_next, ny_next;
  logic [AW-1:0]      idx;

  logic              is_wr, wr_en;
  logic [7:0]        fl_l, fl_t;
  logic signed [8:0] fl_r, fl_b;
  logic              win_ok, full_w;
  out_item_t         res_next;

  assign lw = cfg.rotation[0] ? H_9 : W_9;
  assign lh = cfg.rotation[0] ? W_9 : H_9;

  assign status.clear_last = (clr_addr == LAST_ADDR);
  assign status.out_free   = !result_valid || result_ready;

  // scaled writes halve the source coordinate first
  always_comb begin
    lx     = (act == ACT_SCALED) ? (cx >>> 1) : cx;
    ly     = (act == ACT_SCALED) ? (cy >>> 1) : cy;
    src_ok = cfg.updates_accepted && !cx[11] && !cy[11] &&
             ($signed({cx[11], cx}) < SW_13);
    fits   = ($signed({lx[11], lx}) < $signed({4'd0, lw})) &&
             ($signed({ly[11], ly}) < $signed({4'd0, lh}));
    pre_ok_next = (act != ACT_SCALED) || (src_ok && fits);
    ox_next = {lx[11], lx} + {cfg.x_offset[11], cfg.x_offset};
    oy_next = {ly[11], ly} + {cfg.y_offset[11], cfg.y_offset};
  end

  always_comb begin
    in_bounds = !ox[12] && !oy[12] &&
                (ox[11:0] < {3'd0, lw}) && (oy[11:0] < {3'd0, lh});
    ux = ox[7:0];
    uy = oy[7:0];
    case (cfg.rotation)
      2'd1:    begin nx_next = W_M1 - uy; ny_next = ux;        end
      2'd2:    begin nx_next = W_M1 - ux; ny_next = H_M1 - uy; end
      2'd3:    begin nx_next = uy;        ny_next = H_M1 - ux; end
      default: begin nx_next = ux;        ny_next = uy;        end
    endcase
  end

  assign idx = AW'(nx) + AW'(ny) * W_AW;

  always_comb begin
    is_wr = (act == ACT_WRITE) || (act == ACT_SCALED);
    wr_en = is_wr && hit && cfg.drawing_enabled && (rd_data != color);

    // forced spans are applied before the empty test
    fl_l = fw ? 8'd0 : dl;
    fl_r = fw ? $signed({1'b0, W_M1}) : dr;
    fl_t = fh ? 8'd0 : dt;
    fl_b = fh ? $signed({1'b0, H_M1}) : db;
    win_ok = !((fl_r < $signed({1'b0, fl_l})) || (fl_b < $signed({1'b0, fl_t})));
    full_w = win_ok && ((fl_r[7:0] - fl_l) == W_M1);

    res_next = '0;
    case (act)
      ACT_WRITE, ACT_SCALED: res_next.pixel_changed = wr_en;
      ACT_READ:              res_next.read_color = hit ? rd_data : 16'd0;
      ACT_FLUSH: begin
        if (cfg.updates_accepted && win_ok) begin
          res_next.window_valid      = 1'b1;
          res_next.window_left       = fl_l;
          res_next.window_top        = fl_t;
          res_next.window_right      = fl_r[7:0];
          res_next.window_bottom     = fl_b[7:0];
          res_next.full_width_window = full_w;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_addr] <= COLOR_WHITE;
    end else if (cmd.commit && wr_en) begin
      mem[addr] <= color;
    end
    if (cmd.stage_read) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= item.action;
      cx    <= item.coord_x;
      cy    <= item.coord_y;
      color <= item.pixel_color;
      fw    <= item.full_width_req;
      fh    <= item.full_height_req;
    end
    if (cmd.stage_pre) begin
      ox     <= ox_next;
      oy     <= oy_next;
      pre_ok <= pre_ok_next;
    end
    if (cmd.stage_clip) begin
      nx  <= nx_next;
      ny  <= ny_next;
      hit <= in_bounds && pre_ok;
    end
    if (cmd.stage_read) begin
      addr <= idx;
    end
    if (cmd.commit) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      result_valid <= 1'b0;
      dl           <= W_8;
      dr           <= EMPTY_HI;
      dt           <= H_8;
      db           <= EMPTY_HI;
    end else begin
      if (cmd.clear_step && !status.clear_last) begin
        clr_addr <= clr_addr + ADDR_ONE;
      end
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (wr_en) begin
          // widen bounds to the changed pixel
          if (nx < dl) dl <= nx;
          if ($signed({1'b0, nx}) > dr) dr <= $signed({1'b0, nx});
          if (ny < dt) dt <= ny;
          if ($signed({1'b0, ny}) > db) db <= $signed({1'b0, ny});
        end else if (act == ACT_FLUSH && cfg.updates_accepted) begin
          if (win_ok) begin
            dl <= W_8;
            dr <= EMPTY_HI;
            dt <= H_8;
            db <= EMPTY_HI;
          end else begin
            dl <= fl_l;
            dr <= fl_r;
            dt <= fl_t;
            db <= fl_b;
          end
        end
      end
    end
  end

endmodule

@@ design/framebuffer_dirty_rect_tracker.sv @@
// The controller walks each accepted item through offset, clip/rotate, frame store
// read and compare/write steps, then registers the result beat on the output. A new
// item is taken only once the last is committed; commit waits while the output
// register is full and result_ready is low. Reset: synchronous; bounds go empty,
// registers take their defaults, then the frame store is swept to white at one entry
// a cycle with item_ready low; configuration writes are taken throughout.
`include "framebuffer_dirty_rect_tracker_assert.svh"

module framebuffer_dirty_rect_tracker #(
  parameter int NATIVE_WIDTH  = fbdrt_pkg::NATIVE_WIDTH_DEF,
  parameter int NATIVE_HEIGHT = fbdrt_pkg::NATIVE_HEIGHT_DEF,
  parameter int SOURCE_WIDTH  = fbdrt_pkg::SOURCE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbdrt_pkg::APB_AW-1:0]  paddr,
  input  logic [fbdrt_pkg::APB_DW-1:0]  pwdata,
  output logic [fbdrt_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  fbdrt_pkg::in_item_t           item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output fbdrt_pkg::out_item_t          result
);
  import fbdrt_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  fbdrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbdrt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  fbdrt_datapath #(
    .NATIVE_WIDTH  (NATIVE_WIDTH),
    .NATIVE_HEIGHT (NATIVE_HEIGHT),
    .SOURCE_WIDTH  (SOURCE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `FBDRT_ASSERT_NOW(a_one_step, 1'b1, $onehot0({cmd.clear_step, cmd.load, cmd.stage_pre, cmd.stage_clip, cmd.stage_read, cmd.commit}), "more than one controller step active")
  `FBDRT_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready, "second item accepted while one is in flight")
  `FBDRT_ASSERT_NEXT(a_commit_out, cmd.commit, result_valid, "committed result not presented")
  `FBDRT_ASSERT_NOW(a_window_order, result_valid && result.window_valid, (result.window_left <= result.window_right) && (result.window_top <= result.window_bottom), "flushed window inverted")

endmodule
